[rtl/endl_pkg.sv]
// shared constants, codes and controller/datapath bundles for the node distance lookup
// no dependencies

package endl_pkg;

   localparam int MAX_NODES_DEF  = 1024;
   localparam int COORD_BITS_DEF = 24;
   localparam int NODE_W         = 10;
   localparam int CNT_W          = 11;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic accept;
      logic store_wr;
      logic clear_step;
      logic rd_sel_b;
      logic cap_a;
      logic cap_diff;
      logic sq_en;
      logic sq_sel_y;
      logic acc_load;
      logic acc_add;
      logic root_start;
      logic load_rsp;
      logic rsp_err;
   } cmd_type;

   typedef struct packed {
      logic a_ok;
      logic pair_ok;
      logic clear_last;
      logic root_done;
   } stat_type;

endpackage

[rtl/euclidean_node_distance_lookup.sv]
// top level of the node distance lookup: controller plus datapath
// depends on endl_pkg, endl_ctrl, endl_datapath
//
// usage:
//   req channel (valid/stall): func 0 writes x/y of node_a, func 1 asks for the
//   distance between node_a and node_b. a write to a node at or above the node
//   count is dropped and gives no word; a write keeps the block idle and ready.
//   rsp channel (valid/stall): one word per query, floor(sqrt(dx^2+dy^2)) in
//   q.8 units, or out_of_range set with distance zero when either node is not
//   below the node count (always so with a count of zero).
//   csr port: csr_wr_en/csr_wr_data set the node count and start a clearing
//   sweep of the coordinate store.
// query sequence:
//   a query runs from accept to rsp_valid through two store reads over the
//   single read port, difference, two squares through one shared multiplier,
//   the add, then the bit-serial root at one bit per cycle. an out-of-range
//   query goes from accept straight to the result word, with no reads or
//   root. one item is worked on at a time.
// reset and stall:
//   after reset and after every count write the store is swept to zero, one
//   entry per cycle through all entries, with req_stall high. a finished word
//   waits in the output register while rsp_stall is high; the next item is
//   still taken, and only its own result waits for the register to free.

module euclidean_node_distance_lookup
   import endl_pkg::*;
#(
   parameter int MAX_NODES  = MAX_NODES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [NODE_W-1:0]            req_node_a,
   input  logic [NODE_W-1:0]            req_node_b,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [COORD_BITS:0]          rsp_distance,
   output logic                         rsp_out_of_range,
   input  logic                         csr_wr_en,
   input  logic [CNT_W-1:0]             csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   endl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_func (req_func),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .csr_wr_en(csr_wr_en),
      .stat     (stat),
      .cmd      (cmd)
   );

   endl_datapath #(
      .MAX_NODES (MAX_NODES),
      .COORD_BITS(COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_distance    (rsp_distance),
      .rsp_out_of_range(rsp_out_of_range)
   );

   // no item is taken while the store is being swept
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> req_stall)
      else $error("item accepted during clearing sweep");

   // a count write always starts a sweep
   a_sweep_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> req_stall)
      else $error("count write did not start a sweep");

   // the output register is never overwritten while its word is held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid && rsp_stall))
      else $error("result word overwritten while stalled");

   // an error word carries a zero distance
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp && cmd.rsp_err |=> rsp_valid && rsp_out_of_range && rsp_distance == '0)
      else $error("error word with nonzero distance");

endmodule

[rtl/endl_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies

module endl_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/endl_sqrt.sv]
// bit-serial integer floor square root, one root bit per cycle
// no dependencies

module endl_sqrt #(
   parameter int ROOT_W = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*ROOT_W-1:0]   operand,
   output logic [ROOT_W-1:0]     root,
   output logic                  done
);

   localparam int SUM_W  = 2 * ROOT_W;
   localparam int STEP_W = $clog2(ROOT_W + 1);

   logic [SUM_W-1:0]  n_ff, n_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [ROOT_W+1:0] rem_sh;
   logic [ROOT_W+1:0] trial;
   logic              ge;

   always_comb begin
      // bring down the next two operand bits and try a one in the next root bit
      rem_sh = {rem_ff[ROOT_W-1:0], n_ff[SUM_W-1 -: 2]};
      trial  = {root_ff, 2'b01};
      ge     = (rem_sh >= trial);

      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         n_in    = operand;
         rem_in  = '0;
         root_in = '0;
         step_in = STEP_W'(ROOT_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         n_in    = n_ff << 2;
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

[rtl/endl_datapath.sv]
// datapath: node count, coordinate store with clearing sweep, difference, squares, root
// depends on endl_pkg, endl_ram, endl_sqrt

module endl_datapath
   import endl_pkg::*;
#(
   parameter int MAX_NODES  = MAX_NODES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output stat_type                     stat,
   input  logic [NODE_W-1:0]            req_node_a,
   input  logic [NODE_W-1:0]            req_node_b,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic                         csr_wr_en,
   input  logic [CNT_W-1:0]             csr_wr_data,
   output logic [COORD_BITS:0]          rsp_distance,
   output logic                         rsp_out_of_range
);

   localparam int ADDR_W = $clog2(MAX_NODES);
   localparam int ENT_W  = 2 * COORD_BITS;
   localparam int ROOT_W = COORD_BITS + 1;
   localparam int SUM_W  = 2 * ROOT_W;
   localparam int LIVE_W = ($clog2(MAX_NODES + 1) > CNT_W) ? $clog2(MAX_NODES + 1) : CNT_W;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [ADDR_W-1:0] b_ff, b_in;
   logic [ENT_W-1:0]  pa_ff, pa_in;
   logic [ROOT_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SUM_W-1:0]  sq_ff, sq_in, acc_ff, acc_in;
   logic [ROOT_W-1:0] dist_ff, dist_in;
   logic              oor_ff, oor_in;

   logic [LIVE_W-1:0]        live;
   logic                     b_ok;
   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
   logic [ENT_W-1:0]         ram_wdata, ram_q;
   logic signed [COORD_BITS:0] ddx, ddy;
   logic [ROOT_W-1:0]        mop;
   logic [SUM_W-1:0]         prod;
   logic [ROOT_W-1:0]        root;
   logic                     root_done;

   // a count above capacity acts as the capacity
   assign live = (LIVE_W'(count_ff) > LIVE_W'(MAX_NODES)) ? LIVE_W'(MAX_NODES)
                                                          : LIVE_W'(count_ff);
   assign stat.a_ok       = LIVE_W'(req_node_a) < live;
   assign b_ok            = LIVE_W'(req_node_b) < live;
   assign stat.pair_ok    = stat.a_ok & b_ok;
   assign stat.clear_last = (clr_cnt_ff == ADDR_W'(MAX_NODES - 1));
   assign stat.root_done  = root_done;

   // sweep writes take the port over item writes
   always_comb begin
      ram_we    = cmd.clear_step | cmd.store_wr;
      ram_waddr = cmd.clear_step ? clr_cnt_ff : ADDR_W'(req_node_a);
      ram_wdata = cmd.clear_step ? '0 : {req_coord_x, req_coord_y};
      ram_raddr = cmd.rd_sel_b ? b_ff : ADDR_W'(req_node_a);
   end

   endl_ram #(
      .WIDTH(ENT_W),
      .DEPTH(MAX_NODES)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_q)
   );

   always_comb begin
      ddx  = $signed({pa_ff[ENT_W-1], pa_ff[ENT_W-1:COORD_BITS]})
           - $signed({ram_q[ENT_W-1], ram_q[ENT_W-1:COORD_BITS]});
      ddy  = $signed({pa_ff[COORD_BITS-1], pa_ff[COORD_BITS-1:0]})
           - $signed({ram_q[COORD_BITS-1], ram_q[COORD_BITS-1:0]});
      mop  = cmd.sq_sel_y ? dy_ff : dx_ff;
      prod = mop * mop;
   end

   endl_sqrt #(
      .ROOT_W(ROOT_W)
   ) u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.root_start),
      .operand(acc_ff),
      .root   (root),
      .done   (root_done)
   );

   always_comb begin
      count_in   = count_ff;
      clr_cnt_in = clr_cnt_ff;
      if (csr_wr_en) begin
         count_in   = csr_wr_data;
         clr_cnt_in = '0;
      end else if (cmd.clear_step) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end

      b_in    = cmd.accept ? ADDR_W'(req_node_b) : b_ff;
      pa_in   = cmd.cap_a ? ram_q : pa_ff;
      dx_in   = cmd.cap_diff ? (ddx[COORD_BITS] ? $unsigned(-ddx) : $unsigned(ddx)) : dx_ff;
      dy_in   = cmd.cap_diff ? (ddy[COORD_BITS] ? $unsigned(-ddy) : $unsigned(ddy)) : dy_ff;
      sq_in   = cmd.sq_en ? prod : sq_ff;
      acc_in  = acc_ff;
      if (cmd.acc_load) begin
         acc_in = sq_ff;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + sq_ff;
      end
      dist_in = dist_ff;
      oor_in  = oor_ff;
      if (cmd.load_rsp) begin
         dist_in = cmd.rsp_err ? '0 : root;
         oor_in  = cmd.rsp_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         clr_cnt_ff <= '0;
      end else begin
         count_ff   <= count_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff    <= b_in;
      pa_ff   <= pa_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sq_ff   <= sq_in;
      acc_ff  <= acc_in;
      dist_ff <= dist_in;
      oor_ff  <= oor_in;
   end

   assign rsp_distance     = dist_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

[rtl/endl_ctrl.sv]
// controller state machine: clearing sweep, item accept, query sequencing, result word
// depends on endl_pkg

module endl_ctrl
   import endl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_func,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  logic     csr_wr_en,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      CLEAR,
      IDLE,
      RD_B,
      DIFF,
      SQX,
      SQY,
      SUM,
      ROOT_GO,
      ROOT_WAIT,
      RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      err_ff, err_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      err_in       = err_ff;
      cmd          = '0;
      unique case (state_ff)
         CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_func == FUNC_WRITE) begin
                  cmd.store_wr = stat.a_ok;
               end else if (stat.pair_ok) begin
                  err_in   = 1'b0;
                  state_in = RD_B;
               end else begin
                  err_in   = 1'b1;
                  state_in = RESULT;
               end
            end
         end
         RD_B: begin
            cmd.rd_sel_b = 1'b1;
            cmd.cap_a    = 1'b1;
            state_in     = DIFF;
         end
         DIFF: begin
            cmd.cap_diff = 1'b1;
            state_in     = SQX;
         end
         SQX: begin
            cmd.sq_en = 1'b1;
            state_in  = SQY;
         end
         SQY: begin
            cmd.sq_en    = 1'b1;
            cmd.sq_sel_y = 1'b1;
            cmd.acc_load = 1'b1;
            state_in     = SUM;
         end
         SUM: begin
            cmd.acc_add = 1'b1;
            state_in    = ROOT_GO;
         end
         ROOT_GO: begin
            cmd.root_start = 1'b1;
            state_in       = ROOT_WAIT;
         end
         ROOT_WAIT: begin
            if (stat.root_done) begin
               state_in = RESULT;
            end
         end
         RESULT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_err  = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = CLEAR;
         end
      endcase
      // a count write restarts the clearing sweep
      if (csr_wr_en) begin
         state_in = CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         rsp_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         err_ff       <= err_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[tb/sv/testbench.sv]
// testbench for the node distance lookup: random and directed coordinate writes and queries
// a tracker class mirrors the coordinate store and predicts every distance word
// depends on endl_pkg and euclidean_node_distance_lookup
`timescale 1ns / 1ps

module testbench;
   import endl_pkg::*;

   localparam int NODES      = MAX_NODES_DEF;
   localparam int COORD_W    = COORD_BITS_DEF;
   localparam int DIST_W     = COORD_W + 1;
   localparam int SETTLE     = COORD_W + 16;
   localparam int IDLE_LIMIT = 20000;
   localparam int PHASE_ITEMS = 100;
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              out_of_range;
   } dist_word_type;

   class distance_tracker;
      logic signed [COORD_W-1:0] node_x [NODES];
      logic signed [COORD_W-1:0] node_y [NODES];
      logic [CNT_W-1:0]          node_count;
      dist_word_type             pending_distances[$];
      int                        mismatches;

      function new();
         mismatches = 0;
         set_count('0);
      endfunction

      // a count write also wipes every coordinate
      function void set_count(logic [CNT_W-1:0] value);
         node_count = value;
         foreach (node_x[i]) begin
            node_x[i] = '0;
            node_y[i] = '0;
         end
      endfunction

      function int live_nodes();
         return (node_count > NODES) ? NODES : int'(node_count);
      endfunction

      function logic [DIST_W-1:0] floor_root(longint unsigned n);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int k = DIST_W; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= n) root = trial;
         end
         return root[DIST_W-1:0];
      endfunction

      function void take_request(logic func, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                 logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
         dist_word_type w;
         longint        dx;
         longint        dy;
         int            live;
         live = live_nodes();
         if (func == FUNC_WRITE) begin
            if (a < live) begin
               node_x[a] = x;
               node_y[a] = y;
            end
            return;
         end
         if (a >= live || b >= live) begin
            w.distance     = '0;
            w.out_of_range = 1'b1;
         end else begin
            dx = longint'(node_x[a]) - longint'(node_x[b]);
            dy = longint'(node_y[a]) - longint'(node_y[b]);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            w.distance     = floor_root(longint'(dx * dx + dy * dy));
            w.out_of_range = 1'b0;
         end
         pending_distances.push_back(w);
      endfunction

      function void match_word(logic [DIST_W-1:0] distance, logic out_of_range);
         dist_word_type w;
         if (pending_distances.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected word distance=%0d out_of_range=%0b",
                        $realtime, distance, out_of_range);
            return;
         end
         w = pending_distances.pop_front();
         if (w.distance !== distance || w.out_of_range !== out_of_range) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch expected distance=%0d out_of_range=%0b, got %0d %0b",
                        $realtime, w.distance, w.out_of_range, distance, out_of_range);
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_func;
   logic [NODE_W-1:0]         req_node_a;
   logic [NODE_W-1:0]         req_node_b;
   logic signed [COORD_W-1:0] req_coord_x;
   logic signed [COORD_W-1:0] req_coord_y;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [DIST_W-1:0]         rsp_distance;
   logic                      rsp_out_of_range;
   logic                      csr_wr_en;
   logic [CNT_W-1:0]          csr_wr_data;

   distance_tracker tracker;
   bit              req_lazy = 1'b1;
   bit              rsp_lazy = 1'b1;
   bit              rsp_long_hold = 1'b0;

   euclidean_node_distance_lookup u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_node_a       (req_node_a),
      .req_node_b       (req_node_b),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_distance     (rsp_distance),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.take_request(req_func, req_node_a, req_node_b, req_coord_x, req_coord_y);
         if (rsp_valid && !rsp_stall)
            tracker.match_word(rsp_distance, rsp_out_of_range);
      end
   end

   function automatic logic [NODE_W-1:0] pick_node(int live);
      int sel;
      sel = $urandom_range(99, 0);
      if (live == 0 || sel < 12) return NODE_W'($urandom_range(NODES - 1, 0));
      if (sel < 30) return NODE_W'($urandom_range(live - 1, 0));
      // mostly a small window so queries hit written nodes
      return NODE_W'($urandom_range(((live < 32) ? live : 32) - 1, 0));
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(3, 0))
         0: begin
            case ($urandom_range(3, 0))
               0: return COORD_MAX;
               1: return COORD_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
         1: return COORD_W'($urandom_range(4000, 0) - 2000);
         default: return COORD_W'($urandom());
      endcase
   endfunction

   task automatic send_word(logic func, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                            logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
      int gap;
      gap = req_lazy ? $urandom_range(16, 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_node_a  <= a;
      req_node_b  <= b;
      req_coord_x <= x;
      req_coord_y <= y;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic query(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
      send_word(FUNC_QUERY, a, b, pick_coord(), pick_coord());
   endtask

   task automatic place(logic [NODE_W-1:0] a, logic signed [COORD_W-1:0] x,
                        logic signed [COORD_W-1:0] y);
      send_word(FUNC_WRITE, a, NODE_W'($urandom_range(NODES - 1, 0)), x, y);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_distances.size() != 0);
   endtask

   task automatic write_count(logic [CNT_W-1:0] value);
      drain();
      // a node write may still be landing after the last word
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.set_count(value);
   endtask

   initial begin : stimulus
      int                        useful;
      logic [CNT_W-1:0]          count_value;
      logic                      func;
      logic [NODE_W-1:0]         a;
      logic [NODE_W-1:0]         b;
      int                        live;
      tracker = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_func    <= FUNC_WRITE;
      req_node_a  <= '0;
      req_node_b  <= '0;
      req_coord_x <= '0;
      req_coord_y <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // count of zero: every query flagged, writes dropped
      query(0, 0);
      query(NODE_W'(NODES - 1), NODE_W'(NODES - 1));
      place(0, COORD_MAX, COORD_MAX);

      // count above capacity acts as full capacity
      write_count('1);
      place(NODE_W'(NODES - 1), COORD_MAX, COORD_MAX);
      place(0, COORD_MIN, COORD_MIN);
      query(0, NODE_W'(NODES - 1));
      query(NODE_W'(NODES - 1), 0);
      query(NODE_W'(NODES - 1), NODE_W'(NODES - 1));
      query(0, 5);
      place(5, 24'h555555, 24'hAAAAAA);
      place(6, 24'hAAAAAA, 24'h555555);
      query(5, 6);

      // exact capacity; the count write wipes the store
      write_count(CNT_W'(NODES));
      query(0, NODE_W'(NODES - 1));
      place(512, 3 * 256, 4 * 256);
      query(512, 0);

      // single node
      write_count(1);
      place(0, 24'h000100, -24'sd700);
      place(1, 24'h001000, 24'h001000);
      query(0, 0);
      query(0, 1);
      query(1, 0);

      write_count(2);
      place(1, 1, 0);
      query(0, 1);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: count_value = 16;
            5: count_value = CNT_W'(NODES);
            6: count_value = CNT_W'($urandom_range(2047, 0));
            7: count_value = 3;
            default: count_value = CNT_W'($urandom_range(64, 2));
         endcase
         write_count(count_value);
         if (phase == 2) begin
            // receiver holds off while words keep coming in back to back
            req_lazy      = 1'b0;
            rsp_long_hold = 1'b1;
         end
         useful = 0;
         while (useful < PHASE_ITEMS) begin
            if (phase == 4 && useful == PHASE_ITEMS / 2) drain();
            if (phase != 2 && useful % 25 == 0) req_lazy = ($urandom_range(3, 0) != 0);
            live = tracker.live_nodes();
            func = ($urandom_range(99, 0) < 40) ? FUNC_WRITE : FUNC_QUERY;
            a    = pick_node(live);
            b    = pick_node(live);
            if (func == FUNC_QUERY || a < live) useful++;
            send_word(func, a, b, pick_coord(), pick_coord());
         end
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_distances.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : receiver
      int gap;
      int words;
      words = 0;
      rsp_stall <= 1'b0;
      forever begin
         do @(posedge clock); while (reset || !(rsp_valid && !rsp_stall));
         words++;
         if (words % 40 == 0) rsp_lazy = ($urandom_range(3, 0) != 0);
         if (rsp_long_hold) begin
            gap           = 400;
            rsp_long_hold = 1'b0;
         end else begin
            gap = rsp_lazy ? $urandom_range(16, 0) : 0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("no word moved for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
   end

endmodule
